@@ rtl/core/dpbk_pkg.sv @@
// ----------------------------------------------------------------------------
// dpbk_pkg
// Shared types and constants of the depth pixel back-projection block.
// ----------------------------------------------------------------------------
`default_nettype none

package dpbk_pkg;

	localparam int COORD_W  = 12;
	localparam int DEPTH_W  = 24;
	localparam int INV_W    = 32;
	localparam int CENTER_W = 16;
	localparam int CHAN_W   = 8;
	localparam int POINT_W  = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_COL_LOW     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COL_HIGH    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DEPTH_LIMIT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INV_FX      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INV_FY      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_X    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_COLOR_THR   = 3'd7;

	// Reset values of the configuration registers.
	localparam logic [COORD_W-1:0]  RST_COL_LOW     = 12'd300;
	localparam logic [COORD_W-1:0]  RST_COL_HIGH    = 12'd879;
	localparam logic [DEPTH_W-1:0]  RST_DEPTH_LIMIT = 24'd52429;
	localparam logic [INV_W-1:0]    RST_INV_FX      = 32'd6135667;
	localparam logic [INV_W-1:0]    RST_INV_FY      = 32'd6135667;
	localparam logic [CENTER_W-1:0] RST_CENTER_X    = 16'd10240;
	localparam logic [CENTER_W-1:0] RST_CENTER_Y    = 16'd5760;
	localparam logic [CHAN_W-1:0]   RST_COLOR_THR   = 8'd100;

	// Per-pixel decision flags produced by the qualifier.
	typedef struct packed {
		logic keep;
		logic blue_key;
	} qual_t;

endpackage

`default_nettype wire

@@ rtl/core/dpbk_qual.sv @@
// ----------------------------------------------------------------------------
// dpbk_qual
// Crop window, depth limit and blue color key tests, one registered stage.
// ----------------------------------------------------------------------------
`default_nettype none

module dpbk_qual import dpbk_pkg::*; (
	input  logic                clk,
	input  logic [COORD_W-1:0]  col,
	input  logic [DEPTH_W-1:0]  depth,
	input  logic                depth_valid,
	input  logic [CHAN_W-1:0]   red,
	input  logic [CHAN_W-1:0]   green,
	input  logic [CHAN_W-1:0]   blue,
	input  logic [COORD_W-1:0]  col_low,
	input  logic [COORD_W-1:0]  col_high,
	input  logic [DEPTH_W-1:0]  depth_limit,
	input  logic [CHAN_W-1:0]   color_threshold,
	output qual_t               flags_s1
);

	qual_t flags_c;

	always_comb begin
		flags_c.keep = (col >= col_low) && (col <= col_high) && depth_valid &&
			(depth < depth_limit);
		flags_c.blue_key = (red < color_threshold) && (green < color_threshold) &&
			(blue > color_threshold);
	end

	always_ff @(posedge clk) begin
		flags_s1 <= flags_c;
	end

endmodule

`default_nettype wire

@@ rtl/core/dpbk_axis.sv @@
// ----------------------------------------------------------------------------
// dpbk_axis
// One axis of the pinhole back-projection: offset, two multiply stages,
// rounding, then saturation. Five register stages, result valid after s5.
// ----------------------------------------------------------------------------
`default_nettype none

module dpbk_axis import dpbk_pkg::*; (
	input  logic                clk,
	input  logic [COORD_W-1:0]  coord,
	input  logic [CENTER_W-1:0] center,
	input  logic [INV_W-1:0]    inv,
	input  logic [DEPTH_W-1:0]  z,
	output logic [POINT_W-1:0]  point
);

	localparam int MAG_W  = CENTER_W;
	localparam int A_W    = MAG_W + INV_W;
	localparam int PLO_W  = INV_W + DEPTH_W;
	localparam int PHI_W  = (A_W - INV_W) + DEPTH_W;
	localparam int LOW_W  = PLO_W + 1;
	localparam int SHIFT  = 36;
	localparam int R_W    = PHI_W - 4 + 1;
	localparam logic [LOW_W-1:0] ROUND_BIAS = LOW_W'(1) << (SHIFT - 1);
	localparam logic [R_W-1:0]   POS_MAX    = R_W'(32'h7FFF_FFFF);
	localparam logic [R_W-1:0]   NEG_LIM    = R_W'(32'h8000_0000);

	logic [CENTER_W-1:0] pos_c;
	logic                neg_c;
	logic [MAG_W-1:0]    mag_c;

	logic [MAG_W-1:0]   mag_s1;
	logic               neg_s1;
	logic [DEPTH_W-1:0] z_s1;
	logic [A_W-1:0]     a_s2;
	logic               neg_s2;
	logic [DEPTH_W-1:0] z_s2;
	logic [PLO_W-1:0]   plo_s3;
	logic [PHI_W-1:0]   phi_s3;
	logic               neg_s3;
	logic [LOW_W-1:0]   low_s4;
	logic [PHI_W-5:0]   phi_s4;
	logic               neg_s4;
	logic [R_W-1:0]     r_s5;
	logic               neg_s5;
	logic [R_W-1:0]     r_neg;

	always_comb begin
		pos_c = {coord, 4'b0000};
		neg_c = pos_c < center;
		mag_c = neg_c ? (center - pos_c) : (pos_c - center);
	end

	// The exact product is split at bit 32 of the first product so that each
	// multiplier stays within 32 by 24 bits.
	always_ff @(posedge clk) begin
		mag_s1 <= mag_c;
		neg_s1 <= neg_c;
		z_s1   <= z;

		a_s2   <= A_W'(mag_s1) * A_W'(inv);
		neg_s2 <= neg_s1;
		z_s2   <= z_s1;

		plo_s3 <= PLO_W'(a_s2[INV_W-1:0]) * PLO_W'(z_s2);
		phi_s3 <= PHI_W'(a_s2[A_W-1:INV_W]) * PHI_W'(z_s2);
		neg_s3 <= neg_s2;

		low_s4 <= LOW_W'({phi_s3[3:0], 32'd0}) + LOW_W'(plo_s3) + ROUND_BIAS;
		phi_s4 <= phi_s3[PHI_W-1:4];
		neg_s4 <= neg_s3;

		r_s5   <= R_W'(phi_s4) + R_W'(low_s4[LOW_W-1:SHIFT]);
		neg_s5 <= neg_s4;
	end

	always_comb begin
		r_neg = R_W'(0) - r_s5;
		if (neg_s5) begin
			if (r_s5 >= NEG_LIM) begin
				point = 32'h8000_0000;
			end else begin
				point = r_neg[POINT_W-1:0];
			end
		end else begin
			if (r_s5 > POS_MAX) begin
				point = 32'h7FFF_FFFF;
			end else begin
				point = r_s5[POINT_W-1:0];
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/depth_pixel_backproject_color_key.sv @@
// ----------------------------------------------------------------------------
// depth_pixel_backproject_color_key
// Depth pixel crop, pinhole back-projection and blue color key, pipelined.
// ----------------------------------------------------------------------------
// Each accepted pixel gives one done beat as it leaves the pipeline.
// Throughput: one pixel per cycle; busy stays low, the six-stage pipeline
// (set by the two chained multipliers and the rounding adds) never stalls.
// Reset clears the valid pipeline and loads the configuration defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module depth_pixel_backproject_color_key import dpbk_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic                         cfg_we,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CFG_DATA_W-1:0]        cfg_wdata,
	input  logic [COORD_W-1:0]           col,
	input  logic [COORD_W-1:0]           row,
	input  logic [DEPTH_W-1:0]           depth,
	input  logic                         depth_valid,
	input  logic [CHAN_W-1:0]            red,
	input  logic [CHAN_W-1:0]            green,
	input  logic [CHAN_W-1:0]            blue,
	input  logic                         in_last,
	output logic                         done,
	output logic                         keep,
	output logic                         color_match,
	output logic signed [POINT_W-1:0]    point_x,
	output logic signed [POINT_W-1:0]    point_y,
	output logic [DEPTH_W-1:0]           point_z,
	output logic [CHAN_W-1:0]            out_red,
	output logic [CHAN_W-1:0]            out_green,
	output logic [CHAN_W-1:0]            out_blue,
	output logic                         out_last
);

	typedef struct packed {
		logic [DEPTH_W-1:0] z;
		logic [CHAN_W-1:0]  r;
		logic [CHAN_W-1:0]  g;
		logic [CHAN_W-1:0]  b;
		logic               last;
	} side_t;

	logic [COORD_W-1:0]  col_low_q;
	logic [COORD_W-1:0]  col_high_q;
	logic [DEPTH_W-1:0]  depth_limit_q;
	logic [INV_W-1:0]    inv_fx_q;
	logic [INV_W-1:0]    inv_fy_q;
	logic [CENTER_W-1:0] center_x_q;
	logic [CENTER_W-1:0] center_y_q;
	logic [CHAN_W-1:0]   color_thr_q;

	logic [5:0] vld_q;
	logic       accept;

	qual_t flags_s1;
	qual_t flags_s2;
	qual_t flags_s3;
	qual_t flags_s4;
	qual_t flags_s5;

	side_t side_s1;
	side_t side_s2;
	side_t side_s3;
	side_t side_s4;
	side_t side_s5;

	logic [POINT_W-1:0] px_c;
	logic [POINT_W-1:0] py_c;

	logic                keep_s6;
	logic                match_s6;
	logic [POINT_W-1:0]  px_s6;
	logic [POINT_W-1:0]  py_s6;
	logic [DEPTH_W-1:0]  pz_s6;
	side_t               side_s6;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_low_q     <= RST_COL_LOW;
			col_high_q    <= RST_COL_HIGH;
			depth_limit_q <= RST_DEPTH_LIMIT;
			inv_fx_q      <= RST_INV_FX;
			inv_fy_q      <= RST_INV_FY;
			center_x_q    <= RST_CENTER_X;
			center_y_q    <= RST_CENTER_Y;
			color_thr_q   <= RST_COLOR_THR;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_COL_LOW:     col_low_q     <= cfg_wdata[COORD_W-1:0];
				REG_COL_HIGH:    col_high_q    <= cfg_wdata[COORD_W-1:0];
				REG_DEPTH_LIMIT: depth_limit_q <= cfg_wdata[DEPTH_W-1:0];
				REG_INV_FX:      inv_fx_q      <= cfg_wdata[INV_W-1:0];
				REG_INV_FY:      inv_fy_q      <= cfg_wdata[INV_W-1:0];
				REG_CENTER_X:    center_x_q    <= cfg_wdata[CENTER_W-1:0];
				REG_CENTER_Y:    center_y_q    <= cfg_wdata[CENTER_W-1:0];
				REG_COLOR_THR:   color_thr_q   <= cfg_wdata[CHAN_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[4:0], accept};
		end
	end

	dpbk_qual u_qual (
		.clk             (clk),
		.col             (col),
		.depth           (depth),
		.depth_valid     (depth_valid),
		.red             (red),
		.green           (green),
		.blue            (blue),
		.col_low         (col_low_q),
		.col_high        (col_high_q),
		.depth_limit     (depth_limit_q),
		.color_threshold (color_thr_q),
		.flags_s1        (flags_s1)
	);

	dpbk_axis u_axis_x (
		.clk    (clk),
		.coord  (col),
		.center (center_x_q),
		.inv    (inv_fx_q),
		.z      (depth),
		.point  (px_c)
	);

	dpbk_axis u_axis_y (
		.clk    (clk),
		.coord  (row),
		.center (center_y_q),
		.inv    (inv_fy_q),
		.z      (depth),
		.point  (py_c)
	);

	// Sideband travels alongside the axis pipelines and meets them at s5.
	always_ff @(posedge clk) begin
		side_s1 <= '{z: depth, r: red, g: green, b: blue, last: in_last};
		side_s2 <= side_s1;
		side_s3 <= side_s2;
		side_s4 <= side_s3;
		side_s5 <= side_s4;
		flags_s2 <= flags_s1;
		flags_s3 <= flags_s2;
		flags_s4 <= flags_s3;
		flags_s5 <= flags_s4;

		keep_s6  <= flags_s5.keep;
		match_s6 <= flags_s5.keep && flags_s5.blue_key;
		px_s6    <= flags_s5.keep ? px_c : '0;
		py_s6    <= flags_s5.keep ? py_c : '0;
		pz_s6    <= flags_s5.keep ? side_s5.z : '0;
		side_s6  <= side_s5;
	end

	assign done        = vld_q[5];
	assign keep        = keep_s6;
	assign color_match = match_s6;
	assign point_x     = px_s6;
	assign point_y     = py_s6;
	assign point_z     = pz_s6;
	assign out_red     = side_s6.r;
	assign out_green   = side_s6.g;
	assign out_blue    = side_s6.b;
	assign out_last    = side_s6.last;

endmodule

`default_nettype wire

@@ rtl/core/dpbk_checker.sv @@
// ----------------------------------------------------------------------------
// dpbk_checker
// Port-level checks of the back-projection block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dpbk_checker import dpbk_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic                      busy,
	input  logic [DEPTH_W-1:0]        depth,
	input  logic                      depth_valid,
	input  logic                      in_last,
	input  logic                      done,
	input  logic                      keep,
	input  logic                      color_match,
	input  logic signed [POINT_W-1:0] point_x,
	input  logic signed [POINT_W-1:0] point_y,
	input  logic [DEPTH_W-1:0]        point_z,
	input  logic                      out_last
);

	// Counts cycles since reset so that history from the reset period is ignored.
	logic [2:0] warm_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			warm_q <= '0;
		end else if (warm_q != 3'd7) begin
			warm_q <= warm_q + 3'd1;
		end
	end

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised although the pipeline never stalls");

	a_done_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(warm_q == 3'd7) |-> (done == $past(start && !busy, 6)))
		else $error("done beat does not follow an accepted pixel by six cycles");

	a_drop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !keep) |-> (point_x == 0 && point_y == 0 && point_z == 0 && !color_match))
		else $error("dropped pixel carries nonzero point data");

	a_keep_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(warm_q == 3'd7 && done && keep) |->
		($past(depth_valid, 6) && point_z == $past(depth, 6)))
		else $error("kept pixel does not match its input depth");

	a_last_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(warm_q == 3'd7 && done) |-> (out_last == $past(in_last, 6)))
		else $error("frame end marker misaligned with its beat");

endmodule

bind depth_pixel_backproject_color_key dpbk_checker u_dpbk_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.depth       (depth),
	.depth_valid (depth_valid),
	.in_last     (in_last),
	.done        (done),
	.keep        (keep),
	.color_match (color_match),
	.point_x     (point_x),
	.point_y     (point_y),
	.point_z     (point_z),
	.out_last    (out_last)
);

`default_nettype wire

@@ verif/backproject_checker.sv @@
// ----------------------------------------------------------------------------
// backproject_checker
// Watches the pixel, configuration and result ports of the back-projection
// block. It keeps its own copy of the registers, predicts the cloud point of
// every accepted pixel, and compares each done beat with the oldest
// prediction.
// ----------------------------------------------------------------------------
module backproject_checker import dpbk_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic                      busy,
	input  logic                      cfg_we,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [CFG_DATA_W-1:0]     cfg_wdata,
	input  logic [COORD_W-1:0]        col,
	input  logic [COORD_W-1:0]        row,
	input  logic [DEPTH_W-1:0]        depth,
	input  logic                      depth_valid,
	input  logic [CHAN_W-1:0]         red,
	input  logic [CHAN_W-1:0]         green,
	input  logic [CHAN_W-1:0]         blue,
	input  logic                      in_last,
	input  logic                      done,
	input  logic                      keep,
	input  logic                      color_match,
	input  logic signed [POINT_W-1:0] point_x,
	input  logic signed [POINT_W-1:0] point_y,
	input  logic [DEPTH_W-1:0]        point_z,
	input  logic [CHAN_W-1:0]         out_red,
	input  logic [CHAN_W-1:0]         out_green,
	input  logic [CHAN_W-1:0]         out_blue,
	input  logic                      out_last,
	output int                        failures,
	output int                        outstanding
);

	typedef struct packed {
		logic                keep;
		logic                color_match;
		logic [POINT_W-1:0]  point_x;
		logic [POINT_W-1:0]  point_y;
		logic [DEPTH_W-1:0]  point_z;
		logic [CHAN_W-1:0]   red;
		logic [CHAN_W-1:0]   green;
		logic [CHAN_W-1:0]   blue;
		logic                last;
	} cloud_point_t;

	logic [COORD_W-1:0]  win_low;
	logic [COORD_W-1:0]  win_high;
	logic [DEPTH_W-1:0]  range_limit;
	logic [INV_W-1:0]    recip_fx;
	logic [INV_W-1:0]    recip_fy;
	logic [CENTER_W-1:0] principal_x;
	logic [CENTER_W-1:0] principal_y;
	logic [CHAN_W-1:0]   key_thr;

	cloud_point_t pending_points[$];
	int           mismatches = 0;

	assign failures = mismatches;

	// One axis of the pinhole back-projection: the offset from the principal
	// point in sixteenths of a pixel, times the reciprocal focal length and
	// the depth, scaled down by 2^36 with the magnitude rounded half up, then
	// signed and clamped to 32 bits.
	function automatic logic [POINT_W-1:0] project_axis(
		input logic [COORD_W-1:0]  coord,
		input logic [CENTER_W-1:0] center,
		input logic [INV_W-1:0]    recip,
		input logic [DEPTH_W-1:0]  z
	);
		logic [16:0]        pos;
		logic [16:0]        ctr;
		logic               neg;
		logic [16:0]        mag;
		logic [79:0]        product;
		logic [79:0]        scaled;
		logic [POINT_W-1:0] low_bits;
		pos = {1'b0, coord, 4'b0000};
		ctr = {1'b0, center};
		neg = pos < ctr;
		mag = neg ? (ctr - pos) : (pos - ctr);
		product = 80'(mag) * 80'(recip) * 80'(z);
		scaled = (product + (80'd1 << 35)) >> 36;
		low_bits = scaled[POINT_W-1:0];
		if (neg) begin
			if (scaled >= 80'h8000_0000)
				return 32'h8000_0000;
			return -low_bits;
		end
		if (scaled > 80'h7FFF_FFFF)
			return 32'h7FFF_FFFF;
		return low_bits;
	endfunction

	function automatic cloud_point_t predict_point(
		input logic [COORD_W-1:0] u,
		input logic [COORD_W-1:0] v,
		input logic [DEPTH_W-1:0] z,
		input logic               z_ok,
		input logic [CHAN_W-1:0]  r,
		input logic [CHAN_W-1:0]  g,
		input logic [CHAN_W-1:0]  b,
		input logic               last
	);
		cloud_point_t p;
		logic         kept;
		logic         is_blue;
		kept = (u >= win_low) && (u <= win_high) && z_ok && (z < range_limit);
		is_blue = (r < key_thr) && (g < key_thr) && (b > key_thr);
		p.keep        = kept;
		p.color_match = kept && is_blue;
		p.point_x     = kept ? project_axis(u, principal_x, recip_fx, z) : '0;
		p.point_y     = kept ? project_axis(v, principal_y, recip_fy, z) : '0;
		p.point_z     = kept ? z : '0;
		p.red         = r;
		p.green       = g;
		p.blue        = b;
		p.last        = last;
		return p;
	endfunction

	task automatic check_field(input string field, input logic [31:0] got,
		input logic [31:0] want);
		if (got !== want) begin
			if (mismatches < 10)
				$display("point mismatch on %s: expected %h, got %h", field, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		cloud_point_t want;
		if (!arst_n) begin
			win_low     <= RST_COL_LOW;
			win_high    <= RST_COL_HIGH;
			range_limit <= RST_DEPTH_LIMIT;
			recip_fx    <= RST_INV_FX;
			recip_fy    <= RST_INV_FY;
			principal_x <= RST_CENTER_X;
			principal_y <= RST_CENTER_Y;
			key_thr     <= RST_COLOR_THR;
			pending_points.delete();
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_COL_LOW:     win_low     <= cfg_wdata[COORD_W-1:0];
					REG_COL_HIGH:    win_high    <= cfg_wdata[COORD_W-1:0];
					REG_DEPTH_LIMIT: range_limit <= cfg_wdata[DEPTH_W-1:0];
					REG_INV_FX:      recip_fx    <= cfg_wdata[INV_W-1:0];
					REG_INV_FY:      recip_fy    <= cfg_wdata[INV_W-1:0];
					REG_CENTER_X:    principal_x <= cfg_wdata[CENTER_W-1:0];
					REG_CENTER_Y:    principal_y <= cfg_wdata[CENTER_W-1:0];
					REG_COLOR_THR:   key_thr     <= cfg_wdata[CHAN_W-1:0];
					default: ;
				endcase
			end
			if (done) begin
				if (pending_points.size() == 0) begin
					if (mismatches < 10)
						$display("done beat with no pixel outstanding");
					mismatches++;
				end else begin
					want = pending_points.pop_front();
					check_field("keep", 32'(keep), 32'(want.keep));
					check_field("color_match", 32'(color_match), 32'(want.color_match));
					check_field("point_x", point_x, want.point_x);
					check_field("point_y", point_y, want.point_y);
					check_field("point_z", 32'(point_z), 32'(want.point_z));
					check_field("out_red", 32'(out_red), 32'(want.red));
					check_field("out_green", 32'(out_green), 32'(want.green));
					check_field("out_blue", 32'(out_blue), 32'(want.blue));
					check_field("out_last", 32'(out_last), 32'(want.last));
				end
			end
			if (start && !busy)
				pending_points.insert(pending_points.size(),
					predict_point(col, row, depth, depth_valid,
					red, green, blue, in_last));
			outstanding <= pending_points.size();
		end
	end

endmodule

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives depth pixels and register settings into the back-projection block:
// a directed pass over the crop, depth, color key and saturation corners,
// then phases of random pixels under reset, extreme and random settings.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
	import dpbk_pkg::*;

	localparam int PHASES        = 8;
	localparam int PHASE_PIXELS  = 66;
	localparam int SETTLE_CYCLES = 12;
	localparam int CYCLE_LIMIT   = 100000;

	logic                      clk;
	logic                      arst_n;
	logic                      start;
	logic                      busy;
	logic                      cfg_we;
	logic [CFG_IDX_W-1:0]      cfg_index;
	logic [CFG_DATA_W-1:0]     cfg_wdata;
	logic [COORD_W-1:0]        col;
	logic [COORD_W-1:0]        row;
	logic [DEPTH_W-1:0]        depth;
	logic                      depth_valid;
	logic [CHAN_W-1:0]         red;
	logic [CHAN_W-1:0]         green;
	logic [CHAN_W-1:0]         blue;
	logic                      in_last;
	logic                      done;
	logic                      keep;
	logic                      color_match;
	logic signed [POINT_W-1:0] point_x;
	logic signed [POINT_W-1:0] point_y;
	logic [DEPTH_W-1:0]        point_z;
	logic [CHAN_W-1:0]         out_red;
	logic [CHAN_W-1:0]         out_green;
	logic [CHAN_W-1:0]         out_blue;
	logic                      out_last;
	int                        failures;
	int                        outstanding;

	int unsigned               cycle_count = 0;
	logic                      gaps_on;

	// Current window, limit and threshold, kept only to aim the random pixels.
	logic [COORD_W-1:0]        aim_low;
	logic [COORD_W-1:0]        aim_high;
	logic [DEPTH_W-1:0]        aim_limit;
	logic [CHAN_W-1:0]         aim_thr;

	depth_pixel_backproject_color_key u_dut (.*);

	backproject_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic wait_idle();
		start = 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_wdata = data;
		@(negedge clk);
	endtask

	task automatic write_regs(
		input logic [COORD_W-1:0]  lo,
		input logic [COORD_W-1:0]  hi,
		input logic [DEPTH_W-1:0]  lim,
		input logic [INV_W-1:0]    ifx,
		input logic [INV_W-1:0]    ify,
		input logic [CENTER_W-1:0] cx,
		input logic [CENTER_W-1:0] cy,
		input logic [CHAN_W-1:0]   thr
	);
		wait_idle();
		write_reg(REG_COL_LOW, 32'(lo));
		write_reg(REG_COL_HIGH, 32'(hi));
		write_reg(REG_DEPTH_LIMIT, 32'(lim));
		write_reg(REG_INV_FX, ifx);
		write_reg(REG_INV_FY, ify);
		write_reg(REG_CENTER_X, 32'(cx));
		write_reg(REG_CENTER_Y, 32'(cy));
		write_reg(REG_COLOR_THR, 32'(thr));
		cfg_we    = 1'b0;
		aim_low   = lo;
		aim_high  = hi;
		aim_limit = lim;
		aim_thr   = thr;
	endtask

	// Called at a falling edge; returns at the falling edge after the pixel's
	// beat, with start still high so back-to-back pixels need no gap.
	task automatic send_pixel(
		input logic [COORD_W-1:0] u,
		input logic [COORD_W-1:0] v,
		input logic [DEPTH_W-1:0] z,
		input logic               z_ok,
		input logic [CHAN_W-1:0]  r,
		input logic [CHAN_W-1:0]  g,
		input logic [CHAN_W-1:0]  b,
		input logic               last
	);
		logic taken;
		if (gaps_on) begin
			while ($urandom_range(99) < 30) begin
				start = 1'b0;
				@(negedge clk);
			end
		end
		start       = 1'b1;
		col         = u;
		row         = v;
		depth       = z;
		depth_valid = z_ok;
		red         = r;
		green       = g;
		blue        = b;
		in_last     = last;
		// busy only changes at a rising edge, so its value here is the one
		// the coming edge will see.
		do begin
			taken = !busy;
			@(negedge clk);
		end while (!taken);
	endtask

	task automatic send_random_pixel();
		int unsigned        mode;
		logic [COORD_W-1:0] u;
		logic [COORD_W-1:0] v;
		logic [DEPTH_W-1:0] z;
		logic               z_ok;
		logic [CHAN_W-1:0]  r;
		logic [CHAN_W-1:0]  g;
		logic [CHAN_W-1:0]  b;
		mode = $urandom_range(99);
		u    = 12'($urandom);
		v    = 12'($urandom);
		z    = 24'($urandom);
		z_ok = 1'($urandom);
		r    = 8'($urandom);
		g    = 8'($urandom);
		b    = 8'($urandom);
		if (mode < 60) begin
			// Mostly pixels that survive the crop, so the projection is exercised.
			if (aim_low <= aim_high)
				u = 12'($urandom_range(aim_high, aim_low));
			z_ok = 1'b1;
			if (aim_limit != 0)
				z = 24'($urandom_range(aim_limit - 24'd1, 0));
		end else if (mode < 80) begin
			case ($urandom_range(3))
				0: u = aim_low - 12'd1;
				1: u = aim_low;
				2: u = aim_high;
				default: u = aim_high + 12'd1;
			endcase
			case ($urandom_range(3))
				0: z = aim_limit - 24'd1;
				1: z = aim_limit;
				2: z = '0;
				default: z = '1;
			endcase
			z_ok = ($urandom_range(7) != 0);
		end
		if ($urandom_range(1) == 0) begin
			r = 8'(aim_thr + $urandom_range(2) - 1);
			g = 8'(aim_thr + $urandom_range(2) - 1);
			b = 8'(aim_thr + $urandom_range(2) - 1);
		end
		send_pixel(u, v, z, z_ok, r, g, b, $urandom_range(15) == 0);
	endtask

	initial begin
		logic [COORD_W-1:0] lo;
		logic [COORD_W-1:0] hi;
		arst_n      = 1'b0;
		start       = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = REG_COL_LOW;
		cfg_wdata   = '0;
		col         = '0;
		row         = '0;
		depth       = '0;
		depth_valid = 1'b0;
		red         = '0;
		green       = '0;
		blue        = '0;
		in_last     = 1'b0;
		gaps_on     = 1'b1;
		aim_low     = RST_COL_LOW;
		aim_high    = RST_COL_HIGH;
		aim_limit   = RST_DEPTH_LIMIT;
		aim_thr     = RST_COLOR_THR;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset settings: crop edges, depth limit edge, invalid depth, key edges.
		send_pixel(12'd0, 12'd0, 24'd0, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0);
		send_pixel(12'd4095, 12'd4095, 24'hFFFFFF, 1'b1, 8'd255, 8'd255, 8'd255, 1'b1);
		send_pixel(12'd300, 12'd0, 24'd1000, 1'b1, 8'd99, 8'd99, 8'd101, 1'b0);
		send_pixel(12'd879, 12'd719, 24'd52428, 1'b1, 8'd100, 8'd50, 8'd200, 1'b0);
		send_pixel(12'd880, 12'd100, 24'd1000, 1'b1, 8'd10, 8'd10, 8'd200, 1'b0);
		send_pixel(12'd299, 12'd100, 24'd1000, 1'b1, 8'd10, 8'd10, 8'd200, 1'b0);
		send_pixel(12'd640, 12'd360, 24'd52429, 1'b1, 8'd10, 8'd10, 8'd200, 1'b0);
		send_pixel(12'd640, 12'd360, 24'd30000, 1'b0, 8'd10, 8'd10, 8'd200, 1'b0);
		send_pixel(12'd640, 12'd360, 24'd30000, 1'b1, 8'd10, 8'd10, 8'd100, 1'b0);
		send_pixel(12'd500, 12'd4095, 24'd0, 1'b1, 8'd0, 8'd0, 8'd255, 1'b1);

		// A window whose low column lies above its high column keeps nothing.
		write_regs(12'd700, 12'd600, RST_DEPTH_LIMIT, RST_INV_FX, RST_INV_FY,
			RST_CENTER_X, RST_CENTER_Y, RST_COLOR_THR);
		send_pixel(12'd650, 12'd10, 24'd1000, 1'b1, 8'd0, 8'd0, 8'd255, 1'b0);
		send_pixel(12'd700, 12'd10, 24'd1000, 1'b1, 8'd0, 8'd0, 8'd255, 1'b0);

		// Largest reciprocals and offsets: both coordinates clamp.
		write_regs(12'd0, 12'd4095, 24'hFFFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			16'd0, 16'hFFFF, 8'd0);
		send_pixel(12'd4095, 12'd0, 24'hFFFFFE, 1'b1, 8'd0, 8'd0, 8'd1, 1'b0);
		send_pixel(12'd0, 12'd4095, 24'hFFFFFE, 1'b1, 8'd0, 8'd0, 8'd1, 1'b0);
		send_pixel(12'd1, 12'd1, 24'd1, 1'b1, 8'd0, 8'd0, 8'd0, 1'b1);
		send_pixel(12'd2048, 12'd2048, 24'h008000, 1'b1, 8'd5, 8'd5, 8'd5, 1'b0);

		// Top threshold: blue can never exceed it.
		write_regs(12'd0, 12'd4095, 24'd1, 32'h0100_0000, 32'h0300_0000,
			16'hFFFF, 16'd0, 8'd255);
		send_pixel(12'd10, 12'd10, 24'd0, 1'b1, 8'd0, 8'd0, 8'd255, 1'b0);
		send_pixel(12'd10, 12'd10, 24'd1, 1'b1, 8'd0, 8'd0, 8'd255, 1'b0);

		// Zero depth limit keeps nothing, even a zero depth.
		write_regs(12'd0, 12'd4095, 24'd0, 32'h0100_0000, 32'h0100_0000,
			16'd100, 16'd100, 8'd1);
		send_pixel(12'd5, 12'd5, 24'd0, 1'b1, 8'd0, 8'd0, 8'd2, 1'b1);

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: write_regs(RST_COL_LOW, RST_COL_HIGH, RST_DEPTH_LIMIT, RST_INV_FX,
					RST_INV_FY, RST_CENTER_X, RST_CENTER_Y, RST_COLOR_THR);
				1: write_regs(12'd0, 12'd4095, 24'hFFFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
					16'hFFFF, 16'hFFFF, 8'd255);
				2: write_regs(12'd0, 12'd4095, 24'hFFFFFF, 32'd0, 32'd0,
					16'd0, 16'd0, 8'd0);
				default: begin
					lo = 12'($urandom);
					hi = ($urandom_range(4) == 0) ? 12'($urandom) : 12'($urandom_range(4095, lo));
					write_regs(lo, hi,
						$urandom_range(1) ? 24'($urandom) : 24'($urandom_range(24'h0A0000, 24'h001000)),
						$urandom_range(1) ? $urandom : $urandom_range(32'h0200_0000, 32'h0010_0000),
						$urandom_range(1) ? $urandom : $urandom_range(32'h0200_0000, 32'h0010_0000),
						16'($urandom), 16'($urandom), 8'($urandom));
				end
			endcase
			// One phase streams pixels back to back with no gaps at all.
			gaps_on = (p != 3);
			repeat (PHASE_PIXELS) send_random_pixel();
		end

		wait_idle();
		if (failures == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

@@ depth_pixel_backproject_color_key.f @@
rtl/core/dpbk_pkg.sv
rtl/core/dpbk_qual.sv
rtl/core/dpbk_axis.sv
rtl/core/depth_pixel_backproject_color_key.sv
rtl/core/dpbk_checker.sv
verif/backproject_checker.sv
verif/testbench.sv
